@@ hw/rtl/plst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_pkg
// shared types for the positional list store: words, opcodes, status codes,
// controller states and the command/status bundles between the two halves
// ----------------------------------------------------------------------------
package plst_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_REVERSE   = 3'd6,
    OP_DISPLAY   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLS_INS,
    CLS_DEL,
    CLS_REV,
    CLS_DISP
  } op_class_t;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_ELEMENT = 1'b1;

  // request word
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [7:0]         position;
  } req_t;

  // response word
  typedef struct packed {
    logic               kind;
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_COMMIT,
    S_REV_RD,
    S_REV_WA,
    S_REV_WB,
    S_DISP_RD,
    S_DISP_OUT,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mv_read;
    logic mv_write;
    logic commit;
    logic rev_read;
    logic rev_read_next;
    logic rev_wa;
    logic rev_wb;
    logic disp_read;
    logic emit_elem;
    logic emit_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic      err;
    op_class_t op_class;
    logic      remain_zero;
    logic      remain_one;
    logic      count_zero;
    logic      disp_last;
    logic      out_free;
  } stat_t;

endpackage

@@ hw/rtl/plst_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_datapath
// element memory, count, walk pointers and the response register
// ----------------------------------------------------------------------------
module plst_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  plst_pkg::req_t   req,
  input  plst_pkg::cmd_t   cmd,
  output plst_pkg::stat_t  stat,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output plst_pkg::rsp_t   rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];

  logic [CW-1:0]          count;
  logic [CW-1:0]          ptr;
  logic [CW-1:0]          ptr_b;
  logic [CW-1:0]          remain;
  logic [AW-1:0]          tgt;
  logic [AW-1:0]          wr_addr;
  logic signed [31:0]     value;
  plst_pkg::status_t      res_status;
  plst_pkg::op_class_t    op_class;
  logic signed [31:0]     rdata_a;
  logic signed [31:0]     rdata_b;

  // request decode
  plst_pkg::op_class_t    ld_class;
  plst_pkg::status_t      ld_status;
  logic [CW-1:0]          ld_tgt;
  logic [CW-1:0]          ld_moves;
  logic [CW-1:0]          ld_ptr;
  logic [7:0]             n8;
  logic                   full;

  always_comb begin
    n8        = 8'(count);
    full      = (count == CW'(CAPACITY));
    ld_class  = plst_pkg::CLS_DISP;
    ld_status = plst_pkg::ST_OK;
    ld_tgt    = '0;
    ld_moves  = '0;
    ld_ptr    = '0;
    unique case (plst_pkg::op_t'(req.op))
      plst_pkg::OP_INS_FRONT: begin
        ld_class = plst_pkg::CLS_INS;
        ld_tgt   = '0;
      end
      plst_pkg::OP_INS_END: begin
        ld_class = plst_pkg::CLS_INS;
        ld_tgt   = count;
      end
      plst_pkg::OP_INS_POS: begin
        ld_class = plst_pkg::CLS_INS;
        ld_tgt   = CW'(req.position);
      end
      plst_pkg::OP_DEL_FRONT: begin
        ld_class = plst_pkg::CLS_DEL;
        ld_tgt   = '0;
      end
      plst_pkg::OP_DEL_END: begin
        ld_class = plst_pkg::CLS_DEL;
        ld_tgt   = count - CW'(1);
      end
      plst_pkg::OP_DEL_POS: begin
        ld_class = plst_pkg::CLS_DEL;
        ld_tgt   = CW'(req.position);
      end
      plst_pkg::OP_REVERSE: begin
        ld_class = plst_pkg::CLS_REV;
      end
      plst_pkg::OP_DISPLAY: begin
        ld_class = plst_pkg::CLS_DISP;
      end
      default: begin
        ld_class = plst_pkg::CLS_DISP;
      end
    endcase

    case (ld_class)
      plst_pkg::CLS_INS: begin
        if (plst_pkg::op_t'(req.op) == plst_pkg::OP_INS_POS &&
            req.position != 8'd0 && req.position > n8) begin
          ld_status = plst_pkg::ST_BADPOS;
        end else if (full) begin
          ld_status = plst_pkg::ST_FULL;
        end
        ld_moves = count - ld_tgt;
        ld_ptr   = count - CW'(1);
      end
      plst_pkg::CLS_DEL: begin
        if (count == '0) begin
          ld_status = plst_pkg::ST_EMPTY;
        end else if (plst_pkg::op_t'(req.op) == plst_pkg::OP_DEL_POS &&
                     req.position >= n8) begin
          ld_status = plst_pkg::ST_BADPOS;
        end
        ld_moves = count - CW'(1) - ld_tgt;
        ld_ptr   = ld_tgt + CW'(1);
      end
      plst_pkg::CLS_REV: begin
        ld_moves = count >> 1;
      end
      default: begin
        ld_moves = '0;
      end
    endcase
  end

  // read addresses
  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] ptr_b_dec;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic          rd_a;
  logic          rd_b;

  always_comb begin
    ptr_inc   = ptr + CW'(1);
    ptr_b_dec = ptr_b - CW'(1);
    addr_a    = cmd.rev_read_next ? ptr_inc[AW-1:0] : ptr[AW-1:0];
    addr_b    = cmd.rev_read_next ? ptr_b_dec[AW-1:0] : ptr_b[AW-1:0];
    rd_a      = cmd.mv_read | cmd.disp_read | cmd.rev_read | cmd.rev_read_next;
    rd_b      = cmd.rev_read | cmd.rev_read_next;
  end

  // write port
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  always_comb begin
    we    = 1'b0;
    waddr = wr_addr;
    wdata = rdata_a;
    if (cmd.mv_write) begin
      we = 1'b1;
    end else if (cmd.commit && op_class == plst_pkg::CLS_INS) begin
      we    = 1'b1;
      waddr = tgt;
      wdata = value;
    end else if (cmd.rev_wa) begin
      we    = 1'b1;
      waddr = ptr[AW-1:0];
      wdata = rdata_b;
    end else if (cmd.rev_wb) begin
      we    = 1'b1;
      waddr = ptr_b[AW-1:0];
      wdata = rdata_a;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_a) begin
      rdata_a <= mem[addr_a];
    end
    if (rd_b) begin
      rdata_b <= mem[addr_b];
    end
  end

  // pointers and request registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_class   <= ld_class;
      res_status <= ld_status;
      value      <= req.value;
      tgt        <= ld_tgt[AW-1:0];
      remain     <= ld_moves;
      ptr        <= ld_ptr;
      ptr_b      <= count - CW'(1);
    end else if (cmd.mv_read) begin
      remain <= remain - CW'(1);
      if (op_class == plst_pkg::CLS_INS) begin
        ptr     <= ptr - CW'(1);
        wr_addr <= AW'(ptr + CW'(1));
      end else begin
        ptr     <= ptr + CW'(1);
        wr_addr <= AW'(ptr - CW'(1));
      end
    end else if (cmd.rev_wb) begin
      ptr    <= ptr_inc;
      ptr_b  <= ptr_b_dec;
      remain <= remain - CW'(1);
    end else if (cmd.disp_read) begin
      ptr <= ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      if (op_class == plst_pkg::CLS_INS) begin
        count <= count + CW'(1);
      end else begin
        count <= count - CW'(1);
      end
    end
  end

  // response register
  logic out_free;
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit_elem || cmd.emit_status) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_elem) begin
      rsp.kind    <= plst_pkg::KIND_ELEMENT;
      rsp.status  <= plst_pkg::ST_OK;
      rsp.element <= rdata_a;
      rsp.last    <= (ptr == count);
    end else if (cmd.emit_status) begin
      rsp.kind    <= plst_pkg::KIND_STATUS;
      rsp.status  <= res_status;
      rsp.element <= '0;
      rsp.last    <= 1'b1;
    end
  end

  always_comb begin
    stat.err         = (res_status != plst_pkg::ST_OK);
    stat.op_class    = op_class;
    stat.remain_zero = (remain == '0);
    stat.remain_one  = (remain == CW'(1));
    stat.count_zero  = (count == '0);
    stat.disp_last   = (ptr == count);
    stat.out_free    = out_free;
  end

endmodule

@@ hw/rtl/plst_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_controller
// sequencer that walks the datapath through one request at a time
// ----------------------------------------------------------------------------
module plst_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  plst_pkg::stat_t  stat,
  output plst_pkg::cmd_t   cmd
);

  plst_pkg::state_t state;
  plst_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      plst_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = plst_pkg::S_CHECK;
        end
      end
      plst_pkg::S_CHECK: begin
        if (stat.err) begin
          state_next = plst_pkg::S_EMIT;
        end else begin
          case (stat.op_class)
            plst_pkg::CLS_INS, plst_pkg::CLS_DEL: begin
              state_next = stat.remain_zero ? plst_pkg::S_COMMIT : plst_pkg::S_MOVE_RD;
            end
            plst_pkg::CLS_REV: begin
              state_next = stat.remain_zero ? plst_pkg::S_EMIT : plst_pkg::S_REV_RD;
            end
            default: begin
              state_next = stat.count_zero ? plst_pkg::S_EMIT : plst_pkg::S_DISP_RD;
            end
          endcase
        end
      end
      plst_pkg::S_MOVE_RD: begin
        cmd.mv_read = 1'b1;
        state_next  = plst_pkg::S_MOVE_WR;
      end
      plst_pkg::S_MOVE_WR: begin
        cmd.mv_write = 1'b1;
        if (stat.remain_zero) begin
          state_next = plst_pkg::S_COMMIT;
        end else begin
          cmd.mv_read = 1'b1;
        end
      end
      plst_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = plst_pkg::S_EMIT;
      end
      plst_pkg::S_REV_RD: begin
        cmd.rev_read = 1'b1;
        state_next   = plst_pkg::S_REV_WA;
      end
      plst_pkg::S_REV_WA: begin
        cmd.rev_wa = 1'b1;
        state_next = plst_pkg::S_REV_WB;
      end
      plst_pkg::S_REV_WB: begin
        cmd.rev_wb = 1'b1;
        if (stat.remain_one) begin
          state_next = plst_pkg::S_EMIT;
        end else begin
          cmd.rev_read_next = 1'b1;
          state_next        = plst_pkg::S_REV_WA;
        end
      end
      plst_pkg::S_DISP_RD: begin
        cmd.disp_read = 1'b1;
        state_next    = plst_pkg::S_DISP_OUT;
      end
      plst_pkg::S_DISP_OUT: begin
        if (stat.out_free) begin
          cmd.emit_elem = 1'b1;
          if (stat.disp_last) begin
            state_next = plst_pkg::S_IDLE;
          end else begin
            cmd.disp_read = 1'b1;
          end
        end
      end
      plst_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = plst_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = plst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/positional_list_store_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_unit
// ordered list of up to CAPACITY signed 32-bit values with positional edits
// ----------------------------------------------------------------------------
// Takes one request word at a time and answers it on the response channel.
// Inserts and deletes shift the packed list through a one-write, two-read
// element memory, one element per cycle, up to CAPACITY - 1 elements per
// request. Reverse swaps pairs from both ends inward. Display streams one
// element per cycle, slowed only by stall on the response side. The
// request side stalls until the last response word of the current request
// sits in the output register; that register lets the next request start
// while the final word still waits to be taken.
// ----------------------------------------------------------------------------
module positional_list_store_unit #(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  // request channel
  input  logic            req_valid,
  output logic            req_stall,
  input  plst_pkg::req_t  req,
  // response channel
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output plst_pkg::rsp_t  rsp
);

  // command and status between sequencer and datapath
  plst_pkg::cmd_t  cmd;
  plst_pkg::stat_t stat;

  // sequencer: one request in flight, walks the memory step by step
  plst_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memory, element count, walk pointers and the response register
  plst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

@@ tb/sv/positional_list_store_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_unit_tb
// self-checking bench for the positional list store
// ----------------------------------------------------------------------------
// Drives request words (inserts, deletes, reverse, display) into the unit and
// checks every response word against a behavioral list kept on the bench
// side. Runs an edge-case pass, a fill-to-full pass held off by a long
// response stall, then random traffic under four sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module positional_list_store_unit_tb;
  import plst_pkg::*;

  localparam int CAPACITY = 16;

  // clock, reset and channel signals; the bench-driven ones are known from time zero
  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // bench-side copy of the list, front first
  logic signed [31:0] list_vals [$];
  int unsigned        list_len = 0;

  // response words still owed by the unit, oldest first
  rsp_t expected_words [$];

  // idle mix, in percent of cycles
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  // long receiver hold-off, counted down by the receiver process
  int hold_cycles = 0;

  // run statistics
  int mismatch_count = 0;
  int words_checked  = 0;
  int items_sent     = 0;
  int elems_shown    = 0;
  int full_hits      = 0;
  int empty_hits     = 0;
  int badpos_hits    = 0;

  positional_list_store_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the unit hangs
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_status(status_t st);
    rsp_t w;
    w.kind    = KIND_STATUS;
    w.status  = st;
    w.element = '0;
    w.last    = 1'b1;
    expected_words.push_back(w);
    if (st == ST_FULL) full_hits++;
    if (st == ST_EMPTY) empty_hits++;
    if (st == ST_BADPOS) badpos_hits++;
  endfunction

  function automatic status_t insert_at(int unsigned pos, logic signed [31:0] v);
    if (list_len >= CAPACITY) return ST_FULL;
    list_vals.insert(pos, v);
    list_len++;
    return ST_OK;
  endfunction

  function automatic status_t remove_at(int unsigned pos);
    if (list_len == 0) return ST_EMPTY;
    if (pos >= list_len) return ST_BADPOS;
    list_vals.delete(pos);
    list_len--;
    return ST_OK;
  endfunction

  // work out the response words that one accepted request causes
  function automatic void predict_list_op(req_t w);
    int unsigned        p;
    int unsigned        i;
    rsp_t               e;
    p = 32'(w.position);
    case (op_t'(w.op))
      OP_INS_FRONT: push_status(insert_at(0, w.value));
      OP_INS_END:   push_status(insert_at(list_len, w.value));
      OP_INS_POS: begin
        // position is judged before fullness
        if (p != 0 && p > list_len) push_status(ST_BADPOS);
        else push_status(insert_at(p, w.value));
      end
      OP_DEL_FRONT: push_status(remove_at(0));
      OP_DEL_END: begin
        if (list_len == 0) push_status(ST_EMPTY);
        else push_status(remove_at(list_len - 1));
      end
      OP_DEL_POS: push_status(remove_at(p));
      OP_REVERSE: begin
        list_vals.reverse();
        push_status(ST_OK);
      end
      default: begin
        // display: empty list answers with a plain ok status
        if (list_len == 0) begin
          push_status(ST_OK);
        end else begin
          for (i = 0; i < list_len; i++) begin
            e.kind    = KIND_ELEMENT;
            e.status  = ST_OK;
            e.element = list_vals[i];
            e.last    = (i + 1 == list_len);
            expected_words.push_back(e);
            elems_shown++;
          end
        end
      end
    endcase
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 100)
      $display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // compare every accepted response word with the oldest expectation
  initial begin
    rsp_t e;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", rsp.element, '0);
        end else begin
          e = expected_words.pop_front();
          if (rsp.kind !== e.kind)
            report_mismatch("kind", 32'(rsp.kind), 32'(e.kind));
          if (rsp.status !== e.status)
            report_mismatch("status", 32'(rsp.status), 32'(e.status));
          if (rsp.element !== e.element) report_mismatch("element", rsp.element, e.element);
          if (rsp.last !== e.last)
            report_mismatch("last", 32'(rsp.last), 32'(e.last));
          words_checked++;
        end
      end
    end
  end

  // receiver: long hold-off when asked, otherwise random stall
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_stall <= 1'b1;
        hold_cycles--;
      end else begin
        rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  // ------------------------------------------------------------------- sender

  // offer one word, predict it once taken, then maybe idle for a while;
  // valid stays high on return unless an idle gap was taken
  task automatic send_word(op_t op, logic signed [31:0] value, logic [7:0] position);
    req_valid <= 1'b1;
    req       <= '{op: op, value: value, position: position};
    do @(posedge clk); while (req_stall);
    predict_list_op('{op: op, value: value, position: position});
    items_sent++;
    if ($urandom_range(99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
  endtask

  // hold the sender until every owed word has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // -------------------------------------------------------------------- tests

  // empty-list answers, bad positions, value extremes, reverse and display
  task automatic test_edge_cases();
    send_word(OP_DISPLAY,   32'sd0, 8'd0);
    send_word(OP_DEL_FRONT, 32'sd0, 8'd0);
    send_word(OP_DEL_END,   32'sd0, 8'd0);
    send_word(OP_DEL_POS,   32'sd0, 8'd0);
    send_word(OP_DEL_POS,   32'sd0, 8'd255);
    send_word(OP_REVERSE,   32'sd0, 8'd0);
    // position 1 is out of range while empty
    send_word(OP_INS_POS,   32'sd5, 8'd1);
    send_word(OP_INS_POS,   32'sh7fffffff, 8'd0);
    // single element reverse leaves it alone
    send_word(OP_REVERSE,   32'sd0, 8'd0);
    send_word(OP_INS_FRONT, 32'sh80000000, 8'd0);
    send_word(OP_INS_END,   -32'sd1, 8'd0);
    send_word(OP_INS_END,   32'sd0, 8'd255);
    // insert at count appends, count+1 and up are rejected
    send_word(OP_INS_POS,   32'sh5a5a5a5a, 8'd4);
    send_word(OP_INS_POS,   32'sd1, 8'd6);
    send_word(OP_INS_POS,   32'sd1, 8'd255);
    send_word(OP_INS_POS,   32'sh12345678, 8'd2);
    send_word(OP_DISPLAY,   32'sd0, 8'd0);
    send_word(OP_REVERSE,   32'sd0, 8'd0);
    send_word(OP_DISPLAY,   32'sd0, 8'd0);
    send_word(OP_DEL_POS,   32'sd0, 8'd6);
    send_word(OP_DEL_POS,   32'sd0, 8'd0);
    send_word(OP_DEL_POS,   32'sd0, 8'd2);
    send_word(OP_DEL_END,   32'sd0, 8'd0);
    send_word(OP_DEL_FRONT, 32'sd0, 8'd0);
    send_word(OP_DISPLAY,   32'sd0, 8'd0);
    wait_drained();
  endtask

  // fill to capacity while the receiver holds off, so the unit backs up
  task automatic test_full_list_backpressure();
    hold_cycles = 400;
    while (list_len < CAPACITY) send_word(OP_INS_END, $urandom, 8'($urandom));
    send_word(OP_INS_FRONT, $urandom, 8'd0);
    send_word(OP_INS_END,   $urandom, 8'd0);
    // out-of-range position wins over fullness
    send_word(OP_INS_POS,   $urandom, 8'(CAPACITY + 1));
    send_word(OP_INS_POS,   $urandom, 8'(CAPACITY));
    send_word(OP_DISPLAY,   32'sd0, 8'd0);
    send_word(OP_REVERSE,   32'sd0, 8'd0);
    send_word(OP_DISPLAY,   32'sd0, 8'd0);
    wait_drained();
  endtask

  // random operations with an occupancy target that wanders from empty to full
  task automatic test_random_traffic(int n, int snd_pct, int rcv_pct);
    int   k;
    int   r;
    int   fill_target;
    int   ins_w;
    op_t  op;
    logic [7:0] pos;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    fill_target   = $urandom_range(CAPACITY + 1);
    for (k = 0; k < n; k++) begin
      if (k % 20 == 19) fill_target = $urandom_range(CAPACITY + 1);
      ins_w = (list_len < fill_target) ? 65 : 25;
      r = $urandom_range(99);
      if (r < ins_w) op = op_t'(OP_INS_FRONT + $urandom_range(2));
      else if (r < 86) op = op_t'(OP_DEL_FRONT + $urandom_range(2));
      else if (r < 93) op = OP_REVERSE;
      else op = OP_DISPLAY;
      if ($urandom_range(4) == 0) pos = 8'($urandom_range(255));
      else pos = 8'($urandom_range(list_len + 1));
      send_word(op, $urandom, pos);
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_cases();
    test_full_list_backpressure();
    test_random_traffic(65, 0, 0);
    test_random_traffic(65, 53, 0);
    test_random_traffic(65, 0, 53);
    test_random_traffic(65, 20, 20);

    // let any stray trailing word show up
    repeat (40) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("words never returned", expected_words.size(), 0);

    $display("covered %0d requests and %0d response words (%0d displayed elements)",
             items_sent, words_checked, elems_shown);
    $display("full rejects %0d, empty deletes %0d, bad positions %0d, %0d mismatches",
             full_hits, empty_hits, badpos_hits, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/plst_pkg.sv
hw/rtl/plst_datapath.sv
hw/rtl/plst_controller.sv
hw/rtl/positional_list_store_unit.sv
tb/sv/positional_list_store_unit_tb.sv
